>>> design/afbu_pkg.sv
package afbu_pkg;

  // Operation codes carried on in_mode
  typedef enum logic [2:0] {
    MODE_ID_FWD   = 3'd0,
    MODE_ID_BWD   = 3'd1,
    MODE_RELU_FWD = 3'd2,
    MODE_RELU_BWD = 3'd3,
    MODE_LOG_FWD  = 3'd4,
    MODE_LOG_BWD  = 3'd5
  } afbu_mode_t;

  // 1.0 in unsigned Q2.62, used to build the logistic table
  localparam longint unsigned ONE_Q62 = 64'h4000_0000_0000_0000;

  // floor(a*b / 2^62) for a, b no greater than 2^62
  function automatic longint unsigned mul_q62(input longint unsigned a,
                                              input longint unsigned b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // exp(-1/16) in Q62, summed from its series
  function automatic longint unsigned exp_step_q62();
    longint unsigned c;
    longint unsigned term;
    c    = ONE_Q62;
    term = ONE_Q62;
    for (int n = 1; n <= 24; n++) begin
      term = term / 64'(16 * n);
      if (n[0]) c = c - term;
      else      c = c + term;
    end
    return c;
  endfunction

  // round(2^frac_bits / (1 + e)) with e in Q62, by restoring long division
  function automatic longint unsigned recip_round(input longint unsigned e,
                                                  input int frac_bits);
    longint unsigned d;
    longint unsigned r;
    longint unsigned q;
    d = ONE_Q62 + e;
    r = ONE_Q62;
    q = 0;
    if (r >= d) begin
      r = r - d;
      q = 1;
    end
    for (int n = 0; n < frac_bits + 1; n++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

  // Table entry idx: round(2^frac_bits / (1 + exp(-(idx - half)/16)))
  function automatic logic [31:0] sig_entry(input int idx, input int frac_bits,
                                            input int half);
    longint unsigned c;
    longint unsigned e;
    longint unsigned s;
    longint unsigned one;
    int              k;
    int              m;
    c   = exp_step_q62();
    e   = ONE_Q62;
    one = 64'd1 << frac_bits;
    k   = idx - half;
    m   = (k < 0) ? -k : k;
    for (int i = 0; i < m; i++) begin
      e = mul_q62(e, c);
    end
    s = recip_round(e, frac_bits);
    if (k >= 0) return s[31:0];
    else        return 32'(one - s);
  endfunction

endpackage

>>> design/afbu_sig_rom.sv
module afbu_sig_rom #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRAC_BITS     = 12,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic signed [DATA_WIDTH-1:0] x_i,
  output logic        [FRAC_BITS:0]    s_r
);
  import afbu_pkg::*;

  localparam int SW   = FRAC_BITS + 1;
  localparam int HALF = TABLE_ENTRIES / 2;
  localparam int AW   = $clog2(TABLE_ENTRIES);
  localparam int IW   = 34;
  localparam logic signed [IW-1:0] HALF_S = IW'(HALF);
  localparam logic signed [IW-1:0] TOP_S  = IW'(HALF - 1);

  logic        [SW-1:0]         rom_tbl [TABLE_ENTRIES];
  logic signed [DATA_WIDTH-1:0] shifted;
  logic signed [IW-1:0]         idx;
  logic signed [IW-1:0]         idx_clip;
  logic signed [IW-1:0]         sum;
  logic        [AW-1:0]         addr;
  logic        [SW-1:0]         s_nxt;

  // Build the constant table at elaboration
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_tbl
    localparam logic [31:0] ENTRY = sig_entry(g, FRAC_BITS, HALF);
    assign rom_tbl[g] = SW'(ENTRY);
  end

  // Floor-scale the value to 1/16 steps and clip to the table span
  assign shifted = x_i >>> (FRAC_BITS - 4);
  assign idx     = IW'(shifted);

  always_comb begin
    if (idx < -HALF_S)    idx_clip = -HALF_S;
    else if (idx > TOP_S) idx_clip = TOP_S;
    else                  idx_clip = idx;
  end

  assign sum   = idx_clip + HALF_S;
  assign addr  = sum[AW-1:0];
  assign s_nxt = rom_tbl[addr];

  // Register the table read
  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

endmodule

>>> design/afbu_grad_mul.sv
module afbu_grad_mul #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                   clk,
  input  logic        [FRAC_BITS:0]              s_i,
  input  logic signed [DATA_WIDTH-1:0]           g_i,
  output logic signed [DATA_WIDTH+FRAC_BITS-1:0] gd_r
);
  import afbu_pkg::*;

  localparam int SW = FRAC_BITS + 1;
  localparam int PW = DATA_WIDTH + FRAC_BITS;
  localparam logic [SW-1:0] ONE = SW'(1) << FRAC_BITS;

  logic        [SW-1:0]         one_minus_s;
  logic        [2*SW-1:0]       sd_nxt;
  logic        [2*SW-1:0]       sd_r;
  logic signed [DATA_WIDTH-1:0] g_r;
  logic        [FRAC_BITS-2:0]  deriv;
  logic signed [PW-1:0]         g_ext;
  logic signed [PW-1:0]         d_ext;
  logic signed [PW-1:0]         gd_nxt;

  // First stage: s * (1 - s)
  assign one_minus_s = ONE - s_i;
  assign sd_nxt      = (2 * SW)'(s_i) * (2 * SW)'(one_minus_s);

  always_ff @(posedge clk) begin
    sd_r <= sd_nxt;
    g_r  <= g_i;
  end

  // Second stage: gradient times derivative, derivative floor-scaled
  assign deriv  = sd_r[FRAC_BITS +: FRAC_BITS-1];
  assign g_ext  = PW'(g_r);
  assign d_ext  = PW'($signed({1'b0, deriv}));
  assign gd_nxt = g_ext * d_ext;

  always_ff @(posedge clk) begin
    gd_r <= gd_nxt;
  end

endmodule

>>> design/activation_forward_backward_unit.sv
// An accepted transaction passes the valid registers v1_r to v4_r and out_valid_r before out_valid is high.
// Throughput: one transaction per cycle; busy is always low.
// Depth is set by the table read and the two registered multiplies of the
// logistic derivative path; every mode goes through the same stages.
// Reset (rst_n low, synchronous) clears all stage valid bits; the table is constant.
// The receiver cannot stall: each result shows for exactly one cycle.
module activation_forward_backward_unit #(
  parameter int DATA_WIDTH    = 16,
  parameter int FRAC_BITS     = 12,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_mode,
  input  logic signed [DATA_WIDTH-1:0] in_x_value,
  input  logic signed [DATA_WIDTH-1:0] in_grad_value,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_y_value
);
  import afbu_pkg::*;

  localparam int SW = FRAC_BITS + 1;
  localparam int PW = DATA_WIDTH + FRAC_BITS;
  localparam int WW = DATA_WIDTH + FRAC_BITS + 1;
  localparam logic signed [WW-1:0] MAXV = WW'({1'b0, {(DATA_WIDTH - 1){1'b1}}});
  localparam logic signed [WW-1:0] MINV = ~MAXV;

  logic                         v1_r, v2_r, v3_r, v4_r;
  logic [2:0]                   mode1_r, mode2_r, mode3_r, mode4_r;
  logic signed [DATA_WIDTH-1:0] x1_r, x2_r, x3_r, x4_r;
  logic signed [DATA_WIDTH-1:0] g1_r, g2_r, g3_r, g4_r;
  logic [SW-1:0]                s2;
  logic [SW-1:0]                s3_r, s4_r;
  logic signed [PW-1:0]         gd4;
  logic signed [PW-1:0]         gd_shift;
  logic signed [WW-1:0]         y_wide;
  logic signed [DATA_WIDTH-1:0] y_nxt;
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] y_r;
  logic                         accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Advance valid bits through the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // Carry the payload alongside
  always_ff @(posedge clk) begin
    mode1_r <= in_mode;
    x1_r    <= in_x_value;
    g1_r    <= in_grad_value;
    mode2_r <= mode1_r;
    x2_r    <= x1_r;
    g2_r    <= g1_r;
    mode3_r <= mode2_r;
    x3_r    <= x2_r;
    g3_r    <= g2_r;
    s3_r    <= s2;
    mode4_r <= mode3_r;
    x4_r    <= x3_r;
    g4_r    <= g3_r;
    s4_r    <= s3_r;
  end

  // Logistic table lookup, read registered into stage two
  afbu_sig_rom #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRAC_BITS     (FRAC_BITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_sig_rom (
    .clk (clk),
    .x_i (x1_r),
    .s_r (s2)
  );

  // Logistic gradient product, lands with stage four
  afbu_grad_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_grad_mul (
    .clk  (clk),
    .s_i  (s2),
    .g_i  (g2_r),
    .gd_r (gd4)
  );

  assign gd_shift = gd4 >>> FRAC_BITS;

  // Select the result by mode
  always_comb begin
    case (afbu_mode_t'(mode4_r))
      MODE_ID_FWD:   y_wide = WW'(x4_r);
      MODE_ID_BWD:   y_wide = WW'(g4_r);
      MODE_RELU_FWD: y_wide = (x4_r > 0) ? WW'(x4_r) : '0;
      MODE_RELU_BWD: y_wide = (x4_r > 0) ? WW'(g4_r) : '0;
      MODE_LOG_FWD:  y_wide = $signed(WW'(s4_r));
      MODE_LOG_BWD:  y_wide = WW'(gd_shift);
      default:       y_wide = '0;
    endcase
  end

  // Saturate to the output range
  always_comb begin
    if (y_wide > MAXV)      y_nxt = MAXV[DATA_WIDTH-1:0];
    else if (y_wide < MINV) y_nxt = MINV[DATA_WIDTH-1:0];
    else                    y_nxt = y_wide[DATA_WIDTH-1:0];
  end

  // Hold the result for one strobe cycle
  always_ff @(posedge clk) begin
    y_r <= y_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_y_value = y_r;

endmodule

>>> design/afbu_checker.sv
module afbu_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [2:0]                   in_mode,
  input logic signed [DATA_WIDTH-1:0] in_x_value,
  input logic                         out_valid,
  input logic signed [DATA_WIDTH-1:0] out_y_value
);
  import afbu_pkg::*;

  localparam int LAT = 5;

  logic accept;
  assign accept = start && !busy;

  // The unit never refuses a transaction
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Every accepted transaction yields its strobe after the pipeline depth
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("missing result strobe");

  // No strobe without a transaction in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a transaction");

  // Identity forward passes the value through unchanged
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_ID_FWD) |-> ##LAT out_y_value == $past(in_x_value, LAT))
    else $error("identity forward mismatch");

  // ReLU forward never goes negative
  a_relu_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_RELU_FWD) |-> ##LAT !out_y_value[DATA_WIDTH-1])
    else $error("relu forward negative");

endmodule

bind activation_forward_backward_unit afbu_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_afbu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_mode     (in_mode),
  .in_x_value  (in_x_value),
  .out_valid   (out_valid),
  .out_y_value (out_y_value)
);

>>> dv/activation_forward_backward_unit_tb.sv
`timescale 1ns / 100ps

module activation_forward_backward_unit_tb;
  import afbu_pkg::*;

  localparam int DW = 16;
  localparam int FB = 12;
  localparam int LUT_SIZE = 256;
  localparam int LUT_HALF = LUT_SIZE / 2;
  localparam longint unsigned LUT_ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam int CHUNK_ITEMS = 250;
  localparam int CHUNK_COUNT = 3;

  typedef struct {
    logic [2:0]           mode;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] grad;
  } act_item_t;

  typedef struct {
    act_item_t            item;
    logic signed [DW-1:0] y;
  } act_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [2:0]           in_mode = '0;
  logic signed [DW-1:0] in_x_value = '0;
  logic signed [DW-1:0] in_grad_value = '0;
  logic                 out_valid;
  logic signed [DW-1:0] out_y_value;

  act_item_t   pending_items[$];
  act_result_t expected_y[$];
  int unsigned sigmoid_lut[LUT_SIZE];
  int          error_count = 0;
  int          accepted_count = 0;
  int          checked_count = 0;
  int          mode_count[8];

  activation_forward_backward_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_x_value    (in_x_value),
    .in_grad_value (in_grad_value),
    .out_valid     (out_valid),
    .out_y_value   (out_y_value)
  );

  always #1 clk = ~clk;

  // Build the logistic table: entry half+k from exp(-k/16), mirrored below the midpoint
  function automatic void build_sigmoid_lut();
    longint unsigned exp_step;
    longint unsigned term;
    longint unsigned e;
    logic [127:0]    quot;
    logic [127:0]    prod;
    int unsigned     s;
    exp_step = LUT_ONE_Q62;
    term     = LUT_ONE_Q62;
    for (int n = 1; n <= 24; n++) begin
      term = term / longint'(16 * n);
      if (n % 2 == 1) exp_step = exp_step - term;
      else            exp_step = exp_step + term;
    end
    e = LUT_ONE_Q62;
    for (int k = 0; k <= LUT_HALF; k++) begin
      quot = ({64'd0, LUT_ONE_Q62} << (FB + 1)) / ({64'd0, LUT_ONE_Q62} + {64'd0, e});
      s    = int'((quot + 128'd1) >> 1);
      if (k < LUT_HALF) sigmoid_lut[LUT_HALF + k] = s;
      if (k >= 1) sigmoid_lut[LUT_HALF - k] = (1 << FB) - s;
      prod = {64'd0, e} * {64'd0, exp_step};
      e    = prod[125:62];
    end
  endfunction

  // Compute the activation or the propagated gradient for one transaction
  function automatic logic signed [DW-1:0] activation_result(input act_item_t it);
    longint y;
    longint s;
    longint d;
    int     idx;
    y = 0;
    case (it.mode)
      MODE_ID_FWD:   y = it.x;
      MODE_ID_BWD:   y = it.grad;
      MODE_RELU_FWD: y = (it.x > 0) ? longint'(it.x) : 0;
      MODE_RELU_BWD: y = (it.x > 0) ? longint'(it.grad) : 0;
      MODE_LOG_FWD, MODE_LOG_BWD: begin
        idx = int'(it.x >>> (FB - 4));
        if (idx < -LUT_HALF) idx = -LUT_HALF;
        if (idx > LUT_HALF - 1) idx = LUT_HALF - 1;
        s = sigmoid_lut[idx + LUT_HALF];
        if (it.mode == MODE_LOG_FWD) begin
          y = s;
        end else begin
          d = (s * ((longint'(1) << FB) - s)) >>> FB;
          y = (longint'(it.grad) * d) >>> FB;
        end
      end
      default: y = 0;
    endcase
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] pick_value();
    logic signed [DW-1:0] corner[8];
    corner = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1, -16'sd256, 16'sd255, 16'sd256};
    case ($urandom_range(0, 3))
      0:       return corner[$urandom_range(0, 7)];
      1:       return DW'($urandom_range(0, 2047)) - 16'sd1024;
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic act_item_t random_item();
    act_item_t it;
    if ($urandom_range(0, 99) < 4) it.mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
    else                           it.mode = 3'($urandom_range(0, 5));
    it.x    = pick_value();
    it.grad = pick_value();
    return it;
  endfunction

  function automatic int sender_idle_pct();
    if (accepted_count < 260) return 27;
    if (accepted_count < 520) return 85;
    return 0;
  endfunction

  // Drive the next pending transaction on the falling edge, or idle
  always @(negedge clk) begin
    if (rst_n && pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
      start         <= 1'b1;
      in_mode       <= pending_items[0].mode;
      in_x_value    <= pending_items[0].x;
      in_grad_value <= pending_items[0].grad;
    end else begin
      start         <= 1'b0;
      in_mode       <= 3'($urandom);
      in_x_value    <= DW'($urandom);
      in_grad_value <= DW'($urandom);
    end
  end

  // Record accepted transactions and check each result against the oldest expectation
  always @(posedge clk) begin
    act_item_t   it;
    act_result_t exp_r;
    if (rst_n) begin
      if (start && !busy) begin
        it.mode  = in_mode;
        it.x     = in_x_value;
        it.grad  = in_grad_value;
        exp_r.item = it;
        exp_r.y    = activation_result(it);
        expected_y.insert(expected_y.size(), exp_r);
        void'(pending_items.pop_front());
        accepted_count++;
        mode_count[it.mode]++;
      end
      if (out_valid) begin
        if (expected_y.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result y=%0d with nothing pending", $time, out_y_value);
        end else begin
          exp_r = expected_y.pop_front();
          checked_count++;
          if (out_y_value !== exp_r.y) begin
            error_count++;
            $display("%0t: mode=%0d x=%0d grad=%0d expected y=%0d actual y=%0d", $time,
                     exp_r.item.mode, exp_r.item.x, exp_r.item.grad, exp_r.y, out_y_value);
          end
        end
      end
    end
  end

  // Stimulus: directed corners, then random chunks with a full drain between them
  initial begin
    act_item_t              it;
    logic signed [DW-1:0]   xs[5];
    logic [2:0]             modes[8];
    xs    = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1};
    modes = '{MODE_ID_FWD, MODE_ID_BWD, MODE_RELU_FWD, MODE_RELU_BWD,
              MODE_LOG_FWD, MODE_LOG_BWD, MODE_SPARE_6, MODE_SPARE_7};
    build_sigmoid_lut();
    foreach (mode_count[i]) mode_count[i] = 0;

    // Each defined mode at the value extremes and at zero, with alternating gradient extremes
    for (int m = 0; m < 6; m++) begin
      for (int v = 0; v < 3; v++) begin
        it.mode = modes[m];
        it.x    = xs[v];
        it.grad = (v % 2 == 0) ? 16'sh7FFF : 16'sh8000;
        pending_items.insert(pending_items.size(), it);
      end
    end
    // Values just around zero for the ReLU boundary, and the unused mode codes
    for (int v = 3; v < 5; v++) begin
      it.mode = MODE_RELU_BWD;
      it.x    = xs[v];
      it.grad = 16'sh8000;
      pending_items.insert(pending_items.size(), it);
    end
    for (int m = 6; m < 8; m++) begin
      it.mode = modes[m];
      it.x    = 16'sh7FFF;
      it.grad = 16'sh7FFF;
      pending_items.insert(pending_items.size(), it);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int c = 0; c < CHUNK_COUNT; c++) begin
      // Hold new stimulus until every expected result has drained
      while (pending_items.size() != 0 || expected_y.size() != 0) @(posedge clk);
      for (int i = 0; i < CHUNK_ITEMS; i++) pending_items.insert(pending_items.size(), random_item());
    end

    while (pending_items.size() != 0 || expected_y.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Checked %0d results: id %0d/%0d, relu %0d/%0d, logistic %0d/%0d, unused %0d",
             checked_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
             mode_count[4], mode_count[5], mode_count[6] + mode_count[7]);
    $display("Sender idling at 27%%, 85%% and none, with drains between random chunks");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
